[rtl/bsp_pkg.sv]
// Shared types and constants of the billboard sprite projection core.
// Holds screen geometry, register indexes, divider widths and stage structs.
// Depends on nothing; every other file of the block imports it.
package bsp_pkg;

    localparam int SCREEN_W = 640;
    localparam int SCREEN_H = 480;
    localparam int VERT_DIV = 1;
    localparam int HORZ_DIV = 1;

    // Configuration register indexes.
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_CAM_PX = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CAM_PY = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DIR_X = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DIR_Y = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PLANE_X = 3'd4;
    localparam logic [CFG_IW-1:0] REG_PLANE_Y = 3'd5;
    localparam logic [CFG_IW-1:0] REG_VSHIFT = 3'd6;

    // Divider geometry: numerator magnitude, denominator magnitude, quotient bits.
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 44;
    localparam int DIV_QW = 24;
    localparam int DIV_CW = DIV_DW + DIV_QW;
    localparam int DIV_LAT = DIV_QW + 1;

    typedef struct packed {
        logic signed [15:0] cpx;
        logic signed [15:0] cpy;
        logic signed [15:0] dirx;
        logic signed [15:0] diry;
        logic signed [15:0] plx;
        logic signed [15:0] ply;
        logic signed [15:0] vsc;
    } t_cam;

    typedef struct packed {
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_in;

    typedef struct packed {
        logic [DIV_QW-1:0] q;
        logic ovf;
    } t_quo;

    // Control that travels beside the dividers.
    typedef struct packed {
        logic vld;
        logic depth_neg;
        logic center_neg;
        logic vmove_neg;
        logic det_nz;
        logic ty_nz;
    } t_side;

endpackage

[rtl/bsp_xform.sv]
// Camera transform front end: offsets, inverse camera matrix and divider operands.
// Five register stages; depends on bsp_pkg.
module bsp_xform
    import bsp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [15:0] i_sx,
    input  logic signed [15:0] i_sy,
    input  t_cam               i_cam,
    output t_side              o_side,
    output t_div_in            o_depth,
    output t_div_in            o_center,
    output t_div_in            o_vmove,
    output t_div_in            o_height,
    output t_div_in            o_width
);

    localparam int HALF_W = SCREEN_W / 2;

    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e;
    logic signed [16:0] r_dx, r_dy;
    logic signed [31:0] r_pd1, r_pd2;
    logic signed [32:0] r_m1, r_m2, r_m3, r_m4, r_det_b, r_det_c, r_det_d;
    logic signed [33:0] r_tx, r_ty, r_ty_d;
    logic signed [34:0] r_s;
    logic signed [48:0] r_vd;

    logic [33:0] w_ty_mag;
    logic [32:0] w_det_mag;
    logic [34:0] w_s_mag;
    logic [48:0] w_vd_mag;
    logic [DIV_DW-1:0] w_ty64;

    t_side r_side;
    t_div_in r_depth, r_center, r_vmove, r_height, r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
            r_vld_e <= r_vld_d;
        end
    end

    assign w_ty_mag = r_ty_d[33] ? (~r_ty_d + 34'd1) : r_ty_d;
    assign w_det_mag = r_det_d[32] ? (~r_det_d + 33'd1) : r_det_d;
    assign w_s_mag = r_s[34] ? (~r_s + 35'd1) : r_s;
    assign w_vd_mag = r_vd[48] ? (~r_vd + 49'd1) : r_vd;
    assign w_ty64 = DIV_DW'(w_ty_mag) << 6;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Offset from the camera and the determinant products.
            r_dx <= 17'(i_sx) - 17'(i_cam.cpx);
            r_dy <= 17'(i_sy) - 17'(i_cam.cpy);
            r_pd1 <= i_cam.plx * i_cam.diry;
            r_pd2 <= i_cam.dirx * i_cam.ply;
            // Inverse matrix products.
            r_m1 <= i_cam.diry * r_dx;
            r_m2 <= i_cam.dirx * r_dy;
            r_m3 <= i_cam.plx * r_dy;
            r_m4 <= i_cam.ply * r_dx;
            r_det_b <= 33'(r_pd1) - 33'(r_pd2);
            // Camera-space coordinates.
            r_tx <= 34'(r_m1) - 34'(r_m2);
            r_ty <= 34'(r_m3) - 34'(r_m4);
            r_det_c <= r_det_b;
            // Column sum and the vertical shift numerator.
            r_s <= 35'(r_tx) + 35'(r_ty);
            r_vd <= i_cam.vsc * r_det_c;
            r_ty_d <= r_ty;
            r_det_d <= r_det_c;
            // Unsigned operands and quotient signs.
            r_side.vld <= r_vld_d;
            r_side.depth_neg <= r_ty_d[33] ^ r_det_d[32];
            r_side.center_neg <= r_s[34] ^ r_ty_d[33];
            r_side.vmove_neg <= r_vd[48] ^ r_ty_d[33];
            r_side.det_nz <= (r_det_d != 33'd0);
            r_side.ty_nz <= (r_ty_d != 34'd0);
            r_depth.num <= DIV_NW'(w_ty_mag) << 14;
            r_depth.den <= DIV_DW'(w_det_mag);
            r_center.num <= DIV_NW'(w_s_mag) * DIV_NW'(HALF_W);
            r_center.den <= DIV_DW'(w_ty_mag);
            r_vmove.num <= DIV_NW'(w_vd_mag);
            r_vmove.den <= w_ty64;
            r_height.num <= DIV_NW'(w_det_mag) * DIV_NW'(SCREEN_H);
            r_height.den <= w_ty64 * DIV_DW'(VERT_DIV);
            r_width.num <= DIV_NW'(w_det_mag) * DIV_NW'(SCREEN_H);
            r_width.den <= w_ty64 * DIV_DW'(HORZ_DIV);
        end
    end

    always_comb begin
        o_side = r_side;
        o_side.vld = r_vld_e;
    end

    assign o_depth = r_depth;
    assign o_center = r_center;
    assign o_vmove = r_vmove;
    assign o_height = r_height;
    assign o_width = r_width;

endmodule

[rtl/bsp_div.sv]
// Pipelined restoring divider: one quotient bit per stage plus an overflow stage.
// Quotient saturation is flagged; depends on bsp_pkg.
module bsp_div
    import bsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_div_in i_op,
    output t_quo    o_quo
);

    logic [DIV_NW-1:0] r_rem [0:DIV_QW];
    logic [DIV_DW-1:0] r_den [0:DIV_QW];
    logic [DIV_QW-1:0] r_q [0:DIV_QW];
    logic r_ovf [0:DIV_QW];

    // The quotient does not fit when the numerator reaches den << DIV_QW.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_op.num;
            r_den[0] <= i_op.den;
            r_q[0] <= '0;
            r_ovf[0] <= (DIV_CW'(i_op.num) >= (DIV_CW'(i_op.den) << DIV_QW));
        end
    end

    for (genvar i = 1; i <= DIV_QW; i++) begin : g_stage
        logic [DIV_CW-1:0] w_trial;
        logic w_ge;

        assign w_trial = DIV_CW'(r_den[i-1]) << (DIV_QW - i);
        assign w_ge = (DIV_CW'(r_rem[i-1]) >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= w_ge ? (r_rem[i-1] - w_trial[DIV_NW-1:0]) : r_rem[i-1];
                r_den[i] <= r_den[i-1];
                r_q[i] <= r_q[i-1] | (DIV_QW'(w_ge) << (DIV_QW - i));
                r_ovf[i] <= r_ovf[i-1];
            end
        end
    end

    assign o_quo.q = r_q[DIV_QW];
    assign o_quo.ovf = r_ovf[DIV_QW];

endmodule

[rtl/bsp_bounds.sv]
// Back end: signs and saturates the quotients, then clamps the draw rectangle.
// Two register stages, the second being the output register; depends on bsp_pkg.
module bsp_bounds
    import bsp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_side              i_side,
    input  t_quo               i_depth,
    input  t_quo               i_center,
    input  t_quo               i_vmove,
    input  t_quo               i_height,
    input  t_quo               i_width,
    output logic               o_vld,
    output logic [9:0]         o_draw_start_x,
    output logic [9:0]         o_draw_end_x,
    output logic [8:0]         o_draw_start_y,
    output logic [8:0]         o_draw_end_y,
    output logic signed [15:0] o_screen_center_x,
    output logic [14:0]        o_sprite_width_px,
    output logic [14:0]        o_sprite_height_px,
    output logic signed [15:0] o_vertical_move_px,
    output logic signed [23:0] o_depth,
    output logic               o_behind_camera
);

    localparam logic signed [18:0] MAX_X = 19'(SCREEN_W - 1);
    localparam logic signed [18:0] MAX_Y = 19'(SCREEN_H - 1);
    localparam logic signed [18:0] HALF_H = 19'(SCREEN_H / 2);

    function automatic logic [15:0] sat16(input logic neg, input t_quo qv);
        logic [15:0] res;
        if (neg) begin
            if (qv.ovf || qv.q > 24'd32768) begin
                res = 16'h8000;
            end else begin
                res = 16'(~qv.q + 24'd1);
            end
        end else begin
            if (qv.ovf || qv.q > 24'd32767) begin
                res = 16'h7FFF;
            end else begin
                res = qv.q[15:0];
            end
        end
        return res;
    endfunction

    function automatic logic [14:0] sat15(input t_quo qv);
        logic [14:0] res;
        if (qv.ovf || qv.q > 24'd32767) begin
            res = 15'h7FFF;
        end else begin
            res = qv.q[14:0];
        end
        return res;
    endfunction

    function automatic logic [11:0] clamp(input logic signed [18:0] v,
                                          input logic signed [18:0] hi);
        logic [11:0] res;
        if (v < 19'sd0) begin
            res = '0;
        end else if (v > hi) begin
            res = hi[11:0];
        end else begin
            res = v[11:0];
        end
        return res;
    endfunction

    logic r_vld_f;
    logic signed [15:0] r_center, r_vmove;
    logic [14:0] r_w, r_h;
    logic signed [23:0] r_dep;
    logic r_behind;

    logic signed [23:0] w_dep;
    logic w_proj;
    logic signed [18:0] w_sx, w_ex, w_sy, w_ey;

    assign w_proj = i_side.det_nz && i_side.ty_nz;

    always_comb begin
        w_dep = '0;
        if (i_side.det_nz) begin
            if (i_side.depth_neg) begin
                w_dep = (i_depth.ovf || i_depth.q > 24'h800000) ? 24'h800000
                                                                : (~i_depth.q + 24'd1);
            end else begin
                w_dep = (i_depth.ovf || i_depth.q > 24'h7FFFFF) ? 24'h7FFFFF : i_depth.q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f <= 1'b0;
            o_vld <= 1'b0;
        end else if (i_en) begin
            r_vld_f <= i_side.vld;
            o_vld <= r_vld_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dep <= w_dep;
            r_behind <= w_dep[23] || (w_dep == 24'sd0);
            r_center <= w_proj ? sat16(i_side.center_neg, i_center) : 16'sd0;
            r_vmove <= w_proj ? sat16(i_side.vmove_neg, i_vmove) : 16'sd0;
            r_h <= w_proj ? sat15(i_height) : 15'd0;
            r_w <= w_proj ? sat15(i_width) : 15'd0;
        end
    end

    assign w_sx = 19'(r_center) - 19'(r_w >> 1);
    assign w_ex = 19'(r_center) + 19'(r_w >> 1);
    assign w_sy = HALF_H + 19'(r_vmove) - 19'(r_h >> 1);
    assign w_ey = HALF_H + 19'(r_vmove) + 19'(r_h >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_draw_start_x <= 10'(clamp(w_sx, MAX_X));
            o_draw_end_x <= 10'(clamp(w_ex, MAX_X));
            o_draw_start_y <= 9'(clamp(w_sy, MAX_Y));
            o_draw_end_y <= 9'(clamp(w_ey, MAX_Y));
            o_screen_center_x <= r_center;
            o_sprite_width_px <= r_w;
            o_sprite_height_px <= r_h;
            o_vertical_move_px <= r_vmove;
            o_depth <= r_dep;
            o_behind_camera <= r_behind;
        end
    end

endmodule

[rtl/billboard_sprite_projection_core.sv]
// Top level of the billboard sprite projection core.
// Holds the camera registers and the side-band delay line; uses bsp_pkg,
// bsp_xform, bsp_div and bsp_bounds.
//
// Usage: the camera position, direction, plane and vertical shift scale are
// written through i_cfg_we / i_cfg_idx / i_cfg_wdata while no transaction is in
// flight; indexes past the last register are ignored. Each input transaction
// (i_in_valid with o_in_ready) carries one sprite position, and each output
// transaction (o_out_valid with i_out_ready) returns its projected rectangle,
// sizes, shift, depth and behind flag, in the same order.
// The pipeline has five transform stages (offset, matrix products,
// camera coordinates, operand products, magnitudes), 25 stages of the five
// parallel restoring dividers (overflow check plus one quotient bit each),
// one saturation stage and the output register.
// Throughput is one transaction per cycle while the receiver keeps taking
// results; the divider depth sets the latency, not the rate.
// The whole pipeline advances while the output register is empty or being
// taken. When the receiver stalls with a result waiting, every stage holds,
// o_in_ready drops, and nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and restores the
// camera registers to their defaults.
module billboard_sprite_projection_core
    import bsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_idx,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_sprite_x,
    input  logic signed [15:0]  i_sprite_y,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [9:0]          o_draw_start_x,
    output logic [9:0]          o_draw_end_x,
    output logic [8:0]          o_draw_start_y,
    output logic [8:0]          o_draw_end_y,
    output logic signed [15:0]  o_screen_center_x,
    output logic [14:0]         o_sprite_width_px,
    output logic [14:0]         o_sprite_height_px,
    output logic signed [15:0]  o_vertical_move_px,
    output logic signed [23:0]  o_depth,
    output logic                o_behind_camera
);

    t_cam r_cam;
    logic w_en;
    t_side w_side_e;
    t_side r_side [0:DIV_LAT-1];
    t_div_in w_op_depth, w_op_center, w_op_vmove, w_op_height, w_op_width;
    t_quo w_q_depth, w_q_center, w_q_vmove, w_q_height, w_q_width;

    // The pipeline moves as one while the output register can take a result.
    assign w_en = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam.cpx <= 16'sd0;
            r_cam.cpy <= 16'sd0;
            r_cam.dirx <= 16'sd16384;
            r_cam.diry <= 16'sd0;
            r_cam.plx <= 16'sd0;
            r_cam.ply <= 16'sd10813;
            r_cam.vsc <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAM_PX: begin
                    r_cam.cpx <= i_cfg_wdata;
                end
                REG_CAM_PY: begin
                    r_cam.cpy <= i_cfg_wdata;
                end
                REG_DIR_X: begin
                    r_cam.dirx <= i_cfg_wdata;
                end
                REG_DIR_Y: begin
                    r_cam.diry <= i_cfg_wdata;
                end
                REG_PLANE_X: begin
                    r_cam.plx <= i_cfg_wdata;
                end
                REG_PLANE_Y: begin
                    r_cam.ply <= i_cfg_wdata;
                end
                REG_VSHIFT: begin
                    r_cam.vsc <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    bsp_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (i_in_valid),
        .i_sx     (i_sprite_x),
        .i_sy     (i_sprite_y),
        .i_cam    (r_cam),
        .o_side   (w_side_e),
        .o_depth  (w_op_depth),
        .o_center (w_op_center),
        .o_vmove  (w_op_vmove),
        .o_height (w_op_height),
        .o_width  (w_op_width)
    );

    bsp_div u_div_depth  (.i_clk(i_clk), .i_en(w_en), .i_op(w_op_depth),  .o_quo(w_q_depth));
    bsp_div u_div_center (.i_clk(i_clk), .i_en(w_en), .i_op(w_op_center), .o_quo(w_q_center));
    bsp_div u_div_vmove  (.i_clk(i_clk), .i_en(w_en), .i_op(w_op_vmove),  .o_quo(w_q_vmove));
    bsp_div u_div_height (.i_clk(i_clk), .i_en(w_en), .i_op(w_op_height), .o_quo(w_q_height));
    bsp_div u_div_width  (.i_clk(i_clk), .i_en(w_en), .i_op(w_op_width),  .o_quo(w_q_width));

    // Signs, degenerate flags and valid bits ride beside the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_side[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_side[0] <= w_side_e;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    bsp_bounds u_bounds (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (w_en),
        .i_side             (r_side[DIV_LAT-1]),
        .i_depth            (w_q_depth),
        .i_center           (w_q_center),
        .i_vmove            (w_q_vmove),
        .i_height           (w_q_height),
        .i_width            (w_q_width),
        .o_vld              (o_out_valid),
        .o_draw_start_x     (o_draw_start_x),
        .o_draw_end_x       (o_draw_end_x),
        .o_draw_start_y     (o_draw_start_y),
        .o_draw_end_y       (o_draw_end_y),
        .o_screen_center_x  (o_screen_center_x),
        .o_sprite_width_px  (o_sprite_width_px),
        .o_sprite_height_px (o_sprite_height_px),
        .o_vertical_move_px (o_vertical_move_px),
        .o_depth            (o_depth),
        .o_behind_camera    (o_behind_camera)
    );

    // The behind flag must agree with the depth it was derived from.
    a_behind_matches_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_behind_camera == (o_depth[23] || (o_depth == 24'sd0))))
        else $error("behind flag disagrees with depth");

    // Clamping is monotonic, so the rectangle never turns inside out.
    a_x_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_draw_start_x <= o_draw_end_x))
        else $error("draw start column past end column");

    a_y_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_draw_start_y <= o_draw_end_y))
        else $error("draw start row past end row");

    // A stalled pipeline must keep the valid bit at the end of the side-band line in place.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_side[DIV_LAT-1].vld))
        else $error("side-band valid moved during a stall");

endmodule

[dv/tb_billboard_sprite_projection_core.sv]
// Self-checking testbench of billboard_sprite_projection_core.
// Sprite positions run through a clocked driver and results go to a clocked monitor, which
// checks each one against an in-bench projection model; needs rtl/bsp_pkg.sv and the core.
module tb_billboard_sprite_projection_core;
    import bsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Index past the last register; a write to it must be ignored.
    localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;
    localparam int NUM_REGS = 7;
    localparam int NUM_FIELDS = 10;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } t_sprite;

    typedef struct {
        longint f [NUM_FIELDS];
    } t_proj;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IW-1:0]  i_cfg_idx;
    logic [15:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_sprite_x;
    logic signed [15:0] i_sprite_y;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [9:0]         o_draw_start_x;
    logic [9:0]         o_draw_end_x;
    logic [8:0]         o_draw_start_y;
    logic [8:0]         o_draw_end_y;
    logic signed [15:0] o_screen_center_x;
    logic [14:0]        o_sprite_width_px;
    logic [14:0]        o_sprite_height_px;
    logic signed [15:0] o_vertical_move_px;
    logic signed [23:0] o_depth;
    logic               o_behind_camera;

    billboard_sprite_projection_core uut (.*);

    // The camera registers as the bench believes them to be.
    logic signed [15:0] camera_regs [NUM_REGS];

    t_sprite pending_sprites [$];
    t_proj   expected_projections [$];

    bit      in_taken;
    bit      idling_on;
    int      send_gap;
    int      stall_left;
    int      mismatches;
    int      idle_cycles;

    string field_names [NUM_FIELDS] = '{"draw_start_x", "draw_end_x", "draw_start_y",
        "draw_end_y", "screen_center_x", "sprite_width_px", "sprite_height_px",
        "vertical_move_px", "depth", "behind_camera"};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Projects one sprite with exact 64-bit products and one truncating division per
    // quotient, which is what the pipelined dividers are expected to reproduce.
    function automatic t_proj project_sprite(logic signed [15:0] sx, logic signed [15:0] sy);
        t_proj  r;
        longint dx, dy, det, tx, ty;
        longint depth, center, vmove, width, height, num, den;
        dx = longint'(sx) - longint'(camera_regs[REG_CAM_PX]);
        dy = longint'(sy) - longint'(camera_regs[REG_CAM_PY]);
        det = longint'(camera_regs[REG_PLANE_X]) * longint'(camera_regs[REG_DIR_Y])
            - longint'(camera_regs[REG_DIR_X]) * longint'(camera_regs[REG_PLANE_Y]);
        tx = longint'(camera_regs[REG_DIR_Y]) * dx - longint'(camera_regs[REG_DIR_X]) * dy;
        ty = longint'(camera_regs[REG_PLANE_X]) * dy - longint'(camera_regs[REG_PLANE_Y]) * dx;
        depth = 0;
        center = 0;
        vmove = 0;
        width = 0;
        height = 0;
        if (det != 0) begin
            depth = clip((ty * 16384) / det, -8388608, 8388607);
        end
        // A degenerate matrix or a sprite on the camera line leaves every projected
        // quantity at zero.
        if (det != 0 && ty != 0) begin
            num = magnitude(longint'(SCREEN_H) * det);
            den = magnitude(ty) * 64;
            height = clip(num / (den * VERT_DIV), 0, 32767);
            width = clip(num / (den * HORZ_DIV), 0, 32767);
            center = clip((longint'(SCREEN_W / 2) * (ty + tx)) / ty, -32768, 32767);
            vmove = clip((longint'(camera_regs[REG_VSHIFT]) * det) / (ty * 64),
                -32768, 32767);
        end
        r.f[0] = clip(center - width / 2, 0, SCREEN_W - 1) & 10'h3FF;
        r.f[1] = clip(center + width / 2, 0, SCREEN_W - 1) & 10'h3FF;
        r.f[2] = clip(SCREEN_H / 2 + vmove - height / 2, 0, SCREEN_H - 1) & 9'h1FF;
        r.f[3] = clip(SCREEN_H / 2 + vmove + height / 2, 0, SCREEN_H - 1) & 9'h1FF;
        r.f[4] = center & 16'hFFFF;
        r.f[5] = width & 15'h7FFF;
        r.f[6] = height & 15'h7FFF;
        r.f[7] = vmove & 16'hFFFF;
        r.f[8] = depth & 24'hFFFFFF;
        r.f[9] = (depth <= 0) ? 1 : 0;
        return r;
    endfunction

    // Mostly short gaps, a few long ones; none at all while idling is switched off.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (!idling_on || roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: a new transaction is presented only once the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_sprites.size() > 0) begin
                i_sprite_x <= pending_sprites[0].sx;
                i_sprite_y <= pending_sprites[0].sy;
                void'(pending_sprites.pop_front());
                i_in_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        // The receiver stalls in the same mix of short and long stretches.
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Monitor: predicts at input acceptance, checks at output acceptance.
    always @(posedge i_clk) begin
        t_proj exp_r;
        longint got [NUM_FIELDS];
        bit progress;
        progress = 1'b0;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                progress = 1'b1;
                if (i_cfg_idx < NUM_REGS) camera_regs[i_cfg_idx] = i_cfg_wdata;
            end
            if (i_in_valid && o_in_ready) begin
                progress = 1'b1;
                expected_projections.push_back(project_sprite(i_sprite_x, i_sprite_y));
            end
            if (o_out_valid && i_out_ready) begin
                progress = 1'b1;
                got = '{o_draw_start_x, o_draw_end_x, o_draw_start_y, o_draw_end_y,
                    o_screen_center_x & 16'hFFFF, o_sprite_width_px, o_sprite_height_px,
                    o_vertical_move_px & 16'hFFFF, o_depth & 24'hFFFFFF, o_behind_camera};
                if (expected_projections.size() == 0) begin
                    if (mismatches < 10) $display("unexpected result transaction");
                    mismatches = mismatches + 1;
                end else begin
                    exp_r = expected_projections.pop_front();
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        if (got[k] != exp_r.f[k]) begin
                            if (mismatches < 10) begin
                                $display("%s: expected %0d got %0d", field_names[k],
                                    exp_r.f[k], got[k]);
                            end
                            mismatches = mismatches + 1;
                        end
                    end
                end
            end
            idle_cycles <= progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[billboard_sprite_projection_core] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_sprites.size() > 0 || i_in_valid || expected_projections.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_sprite(logic signed [15:0] sx, logic signed [15:0] sy);
        pending_sprites.push_back('{sx, sy});
    endtask

    // Most sprites sit near the camera so the projection lands on screen; the rest
    // use the whole coordinate range.
    task automatic add_random_sprites(int count);
        int span;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 70) begin
                span = ($urandom_range(3) == 0) ? 16 : 4096;
                add_sprite(
                    16'(camera_regs[REG_CAM_PX] + $signed($urandom_range(2 * span)) - span),
                    16'(camera_regs[REG_CAM_PY] + $signed($urandom_range(2 * span)) - span));
            end else begin
                add_sprite(16'($urandom), 16'($urandom));
            end
        end
    endtask

    // Direction and plane roughly perpendicular like a real camera, with jitter.
    task automatic write_camera();
        logic signed [15:0] ax, ay;
        ax = 16'($signed($urandom_range(32767)) - 16384);
        ay = 16'($signed($urandom_range(32767)) - 16384);
        write_reg(REG_CAM_PX, 16'($urandom));
        write_reg(REG_CAM_PY, 16'($urandom));
        write_reg(REG_DIR_X, ax);
        write_reg(REG_DIR_Y, ay);
        write_reg(REG_PLANE_X, 16'(-ay * 2 / 3 + $signed($urandom_range(64)) - 32));
        write_reg(REG_PLANE_Y, 16'(ax * 2 / 3 + $signed($urandom_range(64)) - 32));
        write_reg(REG_VSHIFT, 16'($urandom));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_CAM_PX;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_sprite_x = '0;
        i_sprite_y = '0;
        i_out_ready = 1'b0;
        in_taken = 1'b0;
        idling_on = 1'b1;
        send_gap = 0;
        stall_left = 0;
        mismatches = 0;
        idle_cycles = 0;
        camera_regs = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd10813, 16'sd0};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed sprites at the reset camera: field extremes, a sprite on the camera
        // itself, one behind, one at tiny depth, and far off-screen ones.
        add_sprite(16'sh8000, 16'sh8000);
        add_sprite(16'sh7FFF, 16'sh7FFF);
        add_sprite(16'sh8000, 16'sh7FFF);
        add_sprite(16'sh7FFF, 16'sh8000);
        add_sprite(16'sd0, 16'sd0);
        add_sprite(16'sd256, 16'sd0);
        add_sprite(-16'sd256, 16'sd0);
        add_sprite(16'sd0, 16'sd256);
        add_sprite(16'sd0, -16'sd256);
        add_sprite(16'sd2560, 16'sd2560);
        add_sprite(16'sd2560, -16'sd2560);
        add_sprite(16'sd1, 16'sd0);
        add_sprite(16'sd0, 16'sd1);
        add_sprite(-16'sd1, -16'sd1);
        add_sprite(16'sd32, 16'sd3000);
        wait_drained();

        // Vertical shift and a camera offset, then sprites near the new camera and random ones.
        write_reg(REG_VSHIFT, 16'sh7FFF);
        write_reg(REG_CAM_PX, 16'sd512);
        write_reg(REG_UNUSED, 16'hFFFF);
        add_sprite(16'sd768, 16'sd0);
        add_sprite(16'sd512, 16'sd1);
        add_sprite(16'sd512, 16'sd0);
        add_sprite(16'sd1024, -16'sd100);
        add_random_sprites(40);
        wait_drained();

        // Singular camera matrix: depth and all projections stay zero.
        write_reg(REG_DIR_X, 16'h0000);
        write_reg(REG_PLANE_Y, 16'h0000);
        add_random_sprites(30);
        wait_drained();

        // Every register at its negative extreme, then every one but plane x at its positive extreme.
        for (int r = 0; r < NUM_REGS; r++) write_reg(r[CFG_IW-1:0], 16'h8000);
        add_random_sprites(40);
        wait_drained();
        for (int r = 0; r < NUM_REGS; r++) write_reg(r[CFG_IW-1:0], 16'h7FFF);
        write_reg(REG_PLANE_X, 16'h8000);
        add_random_sprites(40);
        wait_drained();

        // Random cameras, with one phase run back to back without idling.
        for (int p = 0; p < 9; p++) begin
            idling_on = (p != 4);
            write_camera();
            add_random_sprites(75);
            wait_drained();
        end

        idling_on = 1'b1;
        if (mismatches == 0) begin
            $display("[billboard_sprite_projection_core] OK");
        end else begin
            $display("[billboard_sprite_projection_core] ERROR");
        end
        $finish;
    end

endmodule
